>>> src/gfav_pkg.sv
package gfav_pkg;

    localparam int LEVEL_WIDTH = 16;
    localparam int HOLD_WIDTH  = 8;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = (LEVEL_WIDTH > HOLD_WIDTH) ? LEVEL_WIDTH : HOLD_WIDTH;
    localparam int TRIG_WIDTH  = 5;

    typedef logic signed [LEVEL_WIDTH-1:0] level_t;
    typedef logic [HOLD_WIDTH-1:0]         hold_t;
    typedef logic [CFG_ADDR_WIDTH-1:0]     cfg_addr_t;
    typedef logic [CFG_DATA_WIDTH-1:0]     cfg_data_t;

    localparam hold_t HOLD_RESET = hold_t'(10);

    // register map
    localparam cfg_addr_t REG_CO_THRESHOLD    = cfg_addr_t'(0);
    localparam cfg_addr_t REG_CO2_THRESHOLD   = cfg_addr_t'(1);
    localparam cfg_addr_t REG_SMOKE_THRESHOLD = cfg_addr_t'(2);
    localparam cfg_addr_t REG_TEMP_THRESHOLD  = cfg_addr_t'(3);
    localparam cfg_addr_t REG_IR_THRESHOLD    = cfg_addr_t'(4);
    localparam cfg_addr_t REG_HOLD_TICKS      = cfg_addr_t'(5);

    typedef enum logic [1:0] {
        PATTERN_OFF   = 2'd0,
        PATTERN_WARN  = 2'd1,
        PATTERN_ALARM = 2'd2,
        PATTERN_NONE  = 2'd3
    } pattern_t;

    // five sensor levels, or five matching limits
    typedef struct packed {
        level_t ir;
        level_t temp;
        level_t smoke;
        level_t co2;
        level_t co;
    } levels_t;

    // packs to bit0 co .. bit4 ir
    typedef struct packed {
        logic ir;
        logic temp;
        logic smoke;
        logic co2;
        logic co;
    } trig_t;

endpackage

>>> src/gfav_trigger.sv
module gfav_trigger
    import gfav_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  logic    advance,
    input  levels_t levels,
    input  levels_t limits,
    output logic    stg_valid,
    output trig_t   trig
);

    logic    valid_reg;
    logic    valid_next;
    levels_t levels_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            levels_reg <= levels;
        end
    end

    // strict signed compares against the limits
    assign trig.co    = levels_reg.co    > limits.co;
    assign trig.co2   = levels_reg.co2   > limits.co2;
    assign trig.smoke = levels_reg.smoke > limits.smoke;
    assign trig.temp  = levels_reg.temp  > limits.temp;
    assign trig.ir    = levels_reg.ir    > limits.ir;

    assign stg_valid = valid_reg;

endmodule

>>> src/gfav_latch.sv
module gfav_latch
    import gfav_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  stg_valid,
    input  trig_t                 trig,
    input  hold_t                 hold_ticks,
    output logic                  advance,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_general_alarm,
    output logic                  m_warning_active,
    output logic                  m_obstructed_flag,
    output logic [TRIG_WIDTH-1:0] m_trigger_bits,
    output logic [1:0]            m_display_pattern,
    output logic                  m_pattern_write
);

    logic     alarm_reg, alarm_next;
    logic     warning_reg, warning_next;
    hold_t    hold_count_reg, hold_count_next;
    pattern_t last_pattern_reg;
    pattern_t pattern;
    logic     out_valid_reg, out_valid_next;
    logic [2:0] vote_count;
    logic     vote_alarm, vote_warning, obstructed;

    assign advance = stg_valid && (!out_valid_reg || m_ready);

    assign vote_count = 3'(trig.co) + 3'(trig.co2) + 3'(trig.smoke) + 3'(trig.temp);
    assign vote_alarm   = trig.co || (vote_count >= 3'd2);
    assign vote_warning = !vote_alarm && (vote_count == 3'd1);

    always_comb begin
        alarm_next      = alarm_reg;
        warning_next    = warning_reg;
        hold_count_next = hold_count_reg;
        if (vote_alarm) begin
            alarm_next      = 1'b1;
            warning_next    = 1'b0;
            hold_count_next = hold_ticks;
        end else if (vote_warning && !alarm_reg) begin
            warning_next    = 1'b1;
            hold_count_next = hold_ticks;
        end else if (hold_count_reg != '0) begin
            hold_count_next = hold_count_reg - hold_t'(1);
            if (hold_count_next == '0) begin
                alarm_next   = 1'b0;
                warning_next = 1'b0;
            end
        end
        obstructed = (vote_count == 3'd0) && trig.ir && !alarm_next;
        if (obstructed) begin
            warning_next = 1'b0;
        end
        if (alarm_next) begin
            pattern = PATTERN_ALARM;
        end else if (warning_next || obstructed) begin
            pattern = PATTERN_WARN;
        end else begin
            pattern = PATTERN_OFF;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_reg        <= 1'b0;
            warning_reg      <= 1'b0;
            hold_count_reg   <= '0;
            last_pattern_reg <= PATTERN_NONE;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                alarm_reg        <= alarm_next;
                warning_reg      <= warning_next;
                hold_count_reg   <= hold_count_next;
                last_pattern_reg <= pattern;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_general_alarm   <= alarm_next;
            m_warning_active  <= warning_next;
            m_obstructed_flag <= obstructed;
            m_trigger_bits    <= TRIG_WIDTH'(trig);
            m_display_pattern <= pattern;
            m_pattern_write   <= (pattern != last_pattern_reg);
        end
    end

    assign m_valid = out_valid_reg;

    // alarm and warning latches are exclusive
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(alarm_reg && warning_reg))
        else $error("alarm and warning latched together");

    // a fresh alarm always leaves the alarm latched
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && vote_alarm |=> alarm_reg)
        else $error("fresh alarm did not latch");

    // shown result agrees with the latch state it was taken from
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(advance) |-> (m_general_alarm == alarm_reg)
                           && (m_display_pattern == last_pattern_reg))
        else $error("result out of step with latch state");

    // obstruction shows the warning mark with no latch set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_obstructed_flag |->
            !m_general_alarm && !m_warning_active && (m_display_pattern == PATTERN_WARN))
        else $error("obstruction result inconsistent");

    // a beat waiting at the output does not drop while the pipe advances
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced beat lost");

endmodule

>>> src/gas_fire_alarm_voter_core.sv
// fire and gas alarm voter: each input beat carries five signed q8.8 levels
// (co, co2, smoke, temperature, smoothed ir), each compared strictly above its
// own threshold register. co alone, or any two of the four gas and temperature
// triggers, latch the alarm; exactly one latches a warning unless the alarm is
// already held. each fresh latch reloads the hold counter from hold_ticks, which
// otherwise counts down once per beat and drops both latches on reaching zero
// (a zero hold time keeps the latch until a later reload). ir firing on its own
// with no alarm marks the sensor obstructed and drops the warning. every input
// beat gives exactly one result beat with the display pattern (0 off, 1 warning
// mark, 2 full alarm) and a write strobe set when the pattern differs from the
// one last written. an accepted beat is held in the input register, moves to the
// result register once that is free or its beat is taken, and shows as m_valid from
// then; a new beat is taken every cycle, limited only by m_ready, since the compare
// and latch update are combinational between the input register and the result
// register. write thresholds only while no beat is in flight.
module gas_fire_alarm_voter_core
    import gfav_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration writes
    input  logic                  cfg_we,
    input  cfg_addr_t             cfg_addr,
    input  cfg_data_t             cfg_wdata,

    // sensor beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  level_t                s_co_level,
    input  level_t                s_co2_level,
    input  level_t                s_smoke_level,
    input  level_t                s_temp_level,
    input  level_t                s_ir_level,

    // result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_general_alarm,
    output logic                  m_warning_active,
    output logic                  m_obstructed_flag,
    output logic [TRIG_WIDTH-1:0] m_trigger_bits,
    output logic [1:0]            m_display_pattern,
    output logic                  m_pattern_write
);

    // threshold and hold registers
    levels_t limits_reg;
    hold_t   hold_ticks_reg;

    levels_t levels;
    logic    load;
    logic    advance;
    logic    stg_valid;
    trig_t   trig;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg     <= '0;
            hold_ticks_reg <= HOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CO_THRESHOLD:    limits_reg.co    <= level_t'(cfg_wdata);
                REG_CO2_THRESHOLD:   limits_reg.co2   <= level_t'(cfg_wdata);
                REG_SMOKE_THRESHOLD: limits_reg.smoke <= level_t'(cfg_wdata);
                REG_TEMP_THRESHOLD:  limits_reg.temp  <= level_t'(cfg_wdata);
                REG_IR_THRESHOLD:    limits_reg.ir    <= level_t'(cfg_wdata);
                REG_HOLD_TICKS:      hold_ticks_reg   <= cfg_wdata[HOLD_WIDTH-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // the input register frees when empty or when its beat moves on this cycle
    assign s_ready = !stg_valid || advance;
    assign load    = s_valid && s_ready;

    assign levels.co    = s_co_level;
    assign levels.co2   = s_co2_level;
    assign levels.smoke = s_smoke_level;
    assign levels.temp  = s_temp_level;
    assign levels.ir    = s_ir_level;

    // input register and threshold compares
    gfav_trigger u_trigger (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .advance   (advance),
        .levels    (levels),
        .limits    (limits_reg),
        .stg_valid (stg_valid),
        .trig      (trig)
    );

    // voting, latch state and result register
    gfav_latch u_latch (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .stg_valid         (stg_valid),
        .trig              (trig),
        .hold_ticks        (hold_ticks_reg),
        .advance           (advance),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_general_alarm   (m_general_alarm),
        .m_warning_active  (m_warning_active),
        .m_obstructed_flag (m_obstructed_flag),
        .m_trigger_bits    (m_trigger_bits),
        .m_display_pattern (m_display_pattern),
        .m_pattern_write   (m_pattern_write)
    );

endmodule
